[rtl/core/mjdcal_pkg.sv]
// Types, constants and the month-length table for the MJD to calendar date unit.
`timescale 1ns / 1ps

package mjdcal_pkg;

  // Output field widths
  localparam int unsigned YEAR_W  = 13;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DOM_W   = 5;

  // Day-count offsets: year estimate uses MJD_OFFSET, day of year uses JAN_OFFSET
  localparam int unsigned MJD_OFFSET    = 678940;
  localparam int unsigned JAN_OFFSET    = 678941;
  localparam int unsigned DAYS_PER_YEAR = 365;

  // Reciprocals for exact division by 365 and by 100 (rounded up)
  localparam int unsigned RECIP_W         = 27;
  localparam logic [RECIP_W-1:0] RECIP365 = 27'd94136270;
  localparam int unsigned RECIP365_SHIFT  = 35;
  localparam logic [RECIP_W-1:0] RECIP100 = 27'd42949673;
  localparam int unsigned RECIP100_SHIFT  = 32;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_YEAR,
    ST_MUL365,
    ST_MUL100,
    ST_DOY,
    ST_CHECK,
    ST_LEAP,
    ST_WALK
  } state_e;

  typedef enum logic [1:0] {
    MUL_DIV,
    MUL_Y365,
    MUL_P100,
    MUL_Y100
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     set_year;
    logic     set_base;
    logic     set_doy;
    logic     step_year;
    logic     walk_start;
  } ctl_t;

  typedef struct packed {
    logic             start;
    logic             leap;
    logic [DOY_W-1:0] doy;
  } walk_req_t;

  typedef struct packed {
    logic               done;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   dom;
  } walk_rsp_t;

  // Days in a month, February stretched in leap years
  function automatic logic [DOM_W-1:0] month_len(input logic [MONTH_W-1:0] mon,
                                                 input logic leap);
    logic [DOM_W-1:0] len;
    unique case (mon)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[rtl/core/mjd_to_calendar_date_unit.sv]
// Top level: converts a Modified Julian Day number to a Gregorian calendar date.
`timescale 1ns / 1ps

// A request is taken at a rising edge with start high and busy low; busy then
// stays high until the result has been shown. The result (year, day of year,
// month, day of month) appears for exactly one cycle with valid_o high, and
// busy drops in the cycle after it; the receiver cannot stall, so capture the
// result on that strobe. Only the low MJD_BITS bits of the day number count.
// The year is found in 2 to 5 passes, as the first estimate
// (mjd + 678940) / 365 runs high by one to four years; each pass costs one
// round of three uses of the shared multiplier plus a compare. The month
// number (1 to 12) is then found by the month walker, which steps one month per
// cycle. All divisions by 365 and by 100 go through one shared multiplier
// with fixed reciprocals, one product per cycle.

module mjd_to_calendar_date_unit #(
  parameter int unsigned MJD_BITS = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  input  logic [MJD_BITS-1:0]              mjd_i,
  output logic                             busy,
  output logic                             valid_o,
  output logic [mjdcal_pkg::YEAR_W-1:0]    year_o,
  output logic [mjdcal_pkg::DOY_W-1:0]     day_of_year_o,
  output logic [mjdcal_pkg::MONTH_W-1:0]   month_o,
  output logic [mjdcal_pkg::DOM_W-1:0]     day_of_month_o
);

  // Sum mjd + offset, year and signed day-count widths
  localparam int unsigned SUM_W  = ((MJD_BITS > 20) ? MJD_BITS : 20) + 1;
  localparam int unsigned Y_W    = SUM_W - 8;
  localparam int unsigned PROD_W = SUM_W + mjdcal_pkg::RECIP_W;
  localparam int unsigned DW     = SUM_W + 2;

  mjdcal_pkg::state_e    state_q, state_d;
  mjdcal_pkg::ctl_t      ctl;
  mjdcal_pkg::walk_req_t walk_req;
  mjdcal_pkg::walk_rsp_t walk_rsp;

  logic [MJD_BITS-1:0]                m_q;
  logic [SUM_W-1:0]                   n_q;
  logic [Y_W-1:0]                     y_q;
  logic [Y_W-1:0]                     p;
  logic [Y_W-1:0]                     c;
  logic [Y_W-1:0]                     c1_q;
  logic [PROD_W-1:0]                  prod_q;
  logic [SUM_W-1:0]                   mul_a;
  logic [mjdcal_pkg::RECIP_W-1:0]     mul_b;
  logic [DW-1:0]                      base_q;
  logic [DW-1:0]                      doy_q;
  logic                               retry;
  logic                               leap;

  assign busy = (state_q != mjdcal_pkg::ST_IDLE);

  // Previous year for the leap-day count; y never drops below one
  assign p = y_q - Y_W'(1);

  // Quotient by 100 of whatever the multiplier last worked on
  assign c = prod_q[mjdcal_pkg::RECIP100_SHIFT +: Y_W];

  // Step the year down while the day of year is not yet positive
  assign retry = (doy_q[DW-1] || (doy_q == '0)) && (y_q > Y_W'(1));

  // Leap when y divisible by 4, unless a century year not divisible by 400.
  // y is a century year exactly when y/100 differs from (y-1)/100.
  assign leap = (y_q[1:0] == 2'b00) && ((c == c1_q) || (c[1:0] == 2'b00));

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mjdcal_pkg::ST_IDLE:   if (start) state_d = mjdcal_pkg::ST_DIV;
      mjdcal_pkg::ST_DIV:    state_d = mjdcal_pkg::ST_YEAR;
      mjdcal_pkg::ST_YEAR:   state_d = mjdcal_pkg::ST_MUL365;
      mjdcal_pkg::ST_MUL365: state_d = mjdcal_pkg::ST_MUL100;
      mjdcal_pkg::ST_MUL100: state_d = mjdcal_pkg::ST_DOY;
      mjdcal_pkg::ST_DOY:    state_d = mjdcal_pkg::ST_CHECK;
      mjdcal_pkg::ST_CHECK:  state_d = retry ? mjdcal_pkg::ST_MUL365 : mjdcal_pkg::ST_LEAP;
      mjdcal_pkg::ST_LEAP:   state_d = mjdcal_pkg::ST_WALK;
      mjdcal_pkg::ST_WALK:   if (walk_rsp.done) state_d = mjdcal_pkg::ST_IDLE;
      default:               state_d = mjdcal_pkg::ST_IDLE;
    endcase
  end

  // ---------------- sequencer: control outputs ----------------
  always_comb begin
    ctl = '0;
    ctl.mul_sel = mjdcal_pkg::MUL_DIV;
    unique case (state_q)
      mjdcal_pkg::ST_IDLE: begin
        ctl.load = start;
      end
      mjdcal_pkg::ST_DIV: begin
        // year estimate: (mjd + offset) / 365
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = mjdcal_pkg::MUL_DIV;
      end
      mjdcal_pkg::ST_YEAR: begin
        ctl.set_year = 1'b1;
      end
      mjdcal_pkg::ST_MUL365: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = mjdcal_pkg::MUL_Y365;
      end
      mjdcal_pkg::ST_MUL100: begin
        ctl.mul_en   = 1'b1;
        ctl.mul_sel  = mjdcal_pkg::MUL_P100;
        ctl.set_base = 1'b1;
      end
      mjdcal_pkg::ST_DOY: begin
        ctl.set_doy = 1'b1;
      end
      mjdcal_pkg::ST_CHECK: begin
        // y / 100 for the leap test; wasted if another pass follows
        ctl.mul_en    = 1'b1;
        ctl.mul_sel   = mjdcal_pkg::MUL_Y100;
        ctl.step_year = retry;
      end
      mjdcal_pkg::ST_LEAP: begin
        ctl.walk_start = 1'b1;
      end
      mjdcal_pkg::ST_WALK: begin
        ctl.mul_en = 1'b0;
      end
      default: begin
        ctl.mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mjdcal_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- shared multiplier ----------------
  always_comb begin
    unique case (ctl.mul_sel)
      mjdcal_pkg::MUL_DIV: begin
        mul_a = n_q;
        mul_b = mjdcal_pkg::RECIP365;
      end
      mjdcal_pkg::MUL_Y365: begin
        mul_a = SUM_W'(y_q);
        mul_b = mjdcal_pkg::RECIP_W'(mjdcal_pkg::DAYS_PER_YEAR);
      end
      mjdcal_pkg::MUL_P100: begin
        mul_a = SUM_W'(p);
        mul_b = mjdcal_pkg::RECIP100;
      end
      mjdcal_pkg::MUL_Y100: begin
        mul_a = SUM_W'(y_q);
        mul_b = mjdcal_pkg::RECIP100;
      end
      default: begin
        mul_a = n_q;
        mul_b = mjdcal_pkg::RECIP365;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl.mul_en) begin
      prod_q <= {{mjdcal_pkg::RECIP_W{1'b0}}, mul_a} * {{SUM_W{1'b0}}, mul_b};
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    if (ctl.load) begin
      m_q <= mjd_i;
      n_q <= {{(SUM_W - MJD_BITS){1'b0}}, mjd_i} + SUM_W'(mjdcal_pkg::MJD_OFFSET);
    end
    if (ctl.set_year) begin
      y_q <= prod_q[mjdcal_pkg::RECIP365_SHIFT +: Y_W];
    end else if (ctl.step_year) begin
      y_q <= y_q - Y_W'(1);
    end
    // mjd + 678941 - 365*y; prod holds 365*y here
    if (ctl.set_base) begin
      base_q <= DW'(m_q) + DW'(mjdcal_pkg::JAN_OFFSET) - prod_q[DW-1:0];
    end
    // subtract the leap days before year y: p/4 - p/100 + p/400
    if (ctl.set_doy) begin
      doy_q <= base_q - DW'(p >> 2) + DW'(c) - DW'(c >> 2);
      c1_q  <= c;
    end
  end

  // ---------------- month split ----------------
  assign walk_req.start = ctl.walk_start;
  assign walk_req.leap  = leap;
  assign walk_req.doy   = doy_q[mjdcal_pkg::DOY_W-1:0];

  mjdcal_month_walk u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (walk_req),
    .rsp_o  (walk_rsp)
  );

  // Year and day of year hold until the next request is taken
  assign valid_o        = walk_rsp.done;
  assign year_o         = y_q[mjdcal_pkg::YEAR_W-1:0];
  assign day_of_year_o  = doy_q[mjdcal_pkg::DOY_W-1:0];
  assign month_o        = walk_rsp.month;
  assign day_of_month_o = walk_rsp.dom;

endmodule

[rtl/core/mjdcal_month_walk.sv]
// Month splitter: walks the month lengths one month per cycle.
`timescale 1ns / 1ps

module mjdcal_month_walk (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mjdcal_pkg::walk_req_t req_i,
  output mjdcal_pkg::walk_rsp_t rsp_o
);

  logic                                 active_q, active_d;
  logic                                 done_q, done_d;
  logic                                 leap_q;
  logic [mjdcal_pkg::MONTH_W-1:0]       mon_q;
  logic [mjdcal_pkg::DOY_W-1:0]         rest_q;
  logic [mjdcal_pkg::DOM_W-1:0]         dom_q;
  logic [mjdcal_pkg::DOM_W-1:0]         len;
  logic                                 fits;

  assign len  = mjdcal_pkg::month_len(mon_q, leap_q);
  // December always takes what is left
  assign fits = (rest_q <= {{(mjdcal_pkg::DOY_W - mjdcal_pkg::DOM_W){1'b0}}, len}) ||
                (mon_q == mjdcal_pkg::MONTH_DEC);

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    if (req_i.start) begin
      active_d = 1'b1;
    end else if (active_q && fits) begin
      active_d = 1'b0;
      done_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mon_q  <= mjdcal_pkg::MONTH_JAN;
      rest_q <= req_i.doy;
      leap_q <= req_i.leap;
    end else if (active_q) begin
      if (fits) begin
        dom_q <= rest_q[mjdcal_pkg::DOM_W-1:0];
      end else begin
        rest_q <= rest_q - {{(mjdcal_pkg::DOY_W - mjdcal_pkg::DOM_W){1'b0}}, len};
        mon_q  <= mon_q + 4'd1;
      end
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.month = mon_q;
  assign rsp_o.dom   = dom_q;

endmodule

[rtl/core/mjdcal_checker.sv]
// Port-level checks for the MJD to calendar date unit, bound to the top level.
`timescale 1ns / 1ps

module mjdcal_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic                             valid_o,
  input logic [mjdcal_pkg::DOY_W-1:0]     day_of_year_o,
  input logic [mjdcal_pkg::MONTH_W-1:0]   month_o,
  input logic [mjdcal_pkg::DOM_W-1:0]     day_of_month_o
);

  // A taken request keeps the unit busy
  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after request");

  // Results only come while a request is open, and never twice in a row
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (busy ##1 !valid_o))
    else $error("result outside an open request");

  // Busy drops only right after the result
  a_busy_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(valid_o))
    else $error("busy dropped without a result");

  // Month and day of year stay in calendar range; day of month is at least one
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (month_o >= 4'd1 && month_o <= 4'd12 &&
                 day_of_month_o >= 5'd1 &&
                 day_of_year_o >= 9'd1 && day_of_year_o <= 9'd366))
    else $error("date field out of range");

endmodule

bind mjd_to_calendar_date_unit mjdcal_checker u_mjdcal_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .valid_o        (valid_o),
  .day_of_year_o  (day_of_year_o),
  .month_o        (month_o),
  .day_of_month_o (day_of_month_o)
);
